[rtl/mpac_pkg.sv]
// Shared types and constants for the track-aligning partition entry builder.
// No dependencies; used by mpac_div and mbr_partition_align_chs.
`default_nettype none
package mpac_pkg;

    localparam int DIV_STAGES = 8;   // register stages in one divider
    localparam int DIV_STEPS  = 4;   // quotient bits resolved per stage

    localparam logic [31:0] CYL_LIMIT  = 32'd1023;
    localparam logic [7:0]  BYTE_ONES  = 8'hff;
    localparam logic [5:0]  SPT_RESET  = 6'd63;
    localparam logic [7:0]  HPC_RESET  = 8'd255;

    localparam logic REG_SPT = 1'b0;
    localparam logic REG_HPC = 1'b1;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        bad;
    } side_t;

    typedef struct packed {
        side_t      base;
        logic [7:0] sect_s;   // start sector within track, 0-based
        logic [7:0] sect_e;   // end sector within track, 0-based
    } chs_side_t;

endpackage
`default_nettype wire

[rtl/mbr_partition_align_chs.sv]
// Top level: aligns a partition request to track boundaries and packs CHS bytes.
// Depends on mpac_pkg and mpac_div.
//
//  channel  signals                                   direction
//  in       in_valid/in_ready, start_lba..wants_label  request transaction in
//  out      out_valid/out_ready, status..end_sect_byte result transaction out
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   geometry register write
//
// The pipeline sustains one transaction per cycle while the output is not
// stalled. It is made of four chained 8-stage dividers (start
// remainder, size remainder, sector/track split, head/cylinder split) plus
// three glue stages and the output register. Reset clears valid bits and
// loads geometry 63 sectors, 255 heads. The whole pipeline holds together
// when the output register is full and out_ready is low.
`default_nettype none
module mbr_partition_align_chs (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] start_lba,
    input  wire logic [31:0] size_sectors,
    input  wire logic        wants_label,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             status,
    output logic [31:0]      aligned_start,
    output logic [31:0]      aligned_size,
    output logic [7:0]       start_cyl_byte,
    output logic [7:0]       start_head_byte,
    output logic [7:0]       start_sect_byte,
    output logic [7:0]       end_cyl_byte,
    output logic [7:0]       end_head_byte,
    output logic [7:0]       end_sect_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import mpac_pkg::*;

    logic [5:0] spt_reg;
    logic [7:0] hpc_reg;
    logic       en;
    logic [7:0] spt8;

    // Geometry registers; always ready for a write.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spt_reg <= SPT_RESET;
            hpc_reg <= HPC_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SPT: spt_reg <= cfg_data[5:0];
                REG_HPC: hpc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Advance every stage unless a finished result waits unclaimed.
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign spt8     = {2'b00, spt_reg};

    // ---- Phase A: start / spt ----
    side_t       a_side_reg [DIV_STAGES];
    logic        a_vld_reg  [DIV_STAGES];
    side_t       a_in;
    logic [31:0] a_q;
    logic [7:0]  a_r;

    always_comb
    begin
        a_in.start = start_lba;
        a_in.size  = size_sectors;
        a_in.bad   = wants_label || (spt_reg == '0) || (hpc_reg == '0)
                     || (size_sectors < {26'd0, spt_reg});
    end

    mpac_div u_div_a (
        .clk(clk), .en(en), .dividend(start_lba), .divisor(spt8),
        .quotient(a_q), .remainder(a_r)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_side_reg[0] <= a_in;
            for (int i = 1; i < DIV_STAGES; i++)
                a_side_reg[i] <= a_side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                a_vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg[0] <= in_valid;
            for (int i = 1; i < DIV_STAGES; i++)
                a_vld_reg[i] <= a_vld_reg[i-1];
        end
    end

    // ---- Stage B: round start up to track boundary ----
    side_t b_reg;
    side_t b_next;
    logic  b_vld_reg;

    always_comb
    begin
        b_next = a_side_reg[DIV_STAGES-1];
        if (a_r != '0)
        begin
            b_next.size  = b_next.size - {24'd0, spt8} + {24'd0, a_r};
            b_next.start = b_next.start - {24'd0, a_r} + {24'd0, spt8};
        end
    end

    // ---- Phase B: size / spt ----
    side_t       bb_side_reg [DIV_STAGES];
    logic        bb_vld_reg  [DIV_STAGES];
    logic [31:0] bb_q;
    logic [7:0]  bb_r;

    mpac_div u_div_b (
        .clk(clk), .en(en), .dividend(b_reg.size), .divisor(spt8),
        .quotient(bb_q), .remainder(bb_r)
    );

    // ---- Stage C: truncate size, Stage D: last sector ----
    side_t       c_reg;
    side_t       c_next;
    logic        c_vld_reg;
    side_t       d_reg;
    logic [31:0] end_reg;
    logic        d_vld_reg;

    always_comb
    begin
        c_next      = bb_side_reg[DIV_STAGES-1];
        c_next.size = c_next.size - {24'd0, bb_r};
        c_next.bad  = c_next.bad || (c_next.size < {24'd0, spt8});
    end

    // ---- Phase D: sector within track for start and end ----
    side_t       dd_side_reg [DIV_STAGES];
    logic        dd_vld_reg  [DIV_STAGES];
    logic [31:0] ds_q;
    logic [7:0]  ds_r;
    logic [31:0] de_q;
    logic [7:0]  de_r;

    mpac_div u_div_ds (
        .clk(clk), .en(en), .dividend(d_reg.start), .divisor(spt8),
        .quotient(ds_q), .remainder(ds_r)
    );
    mpac_div u_div_de (
        .clk(clk), .en(en), .dividend(end_reg), .divisor(spt8),
        .quotient(de_q), .remainder(de_r)
    );

    // ---- Phase E: head and cylinder ----
    chs_side_t   ee_side_reg [DIV_STAGES];
    logic        ee_vld_reg  [DIV_STAGES];
    chs_side_t   ee_in;
    logic [31:0] es_q;
    logic [7:0]  es_r;
    logic [31:0] ee_q;
    logic [7:0]  ee_r;

    assign ee_in = '{base: dd_side_reg[DIV_STAGES-1], sect_s: ds_r, sect_e: de_r};

    mpac_div u_div_es (
        .clk(clk), .en(en), .dividend(ds_q), .divisor(hpc_reg),
        .quotient(es_q), .remainder(es_r)
    );
    mpac_div u_div_ee (
        .clk(clk), .en(en), .dividend(de_q), .divisor(hpc_reg),
        .quotient(ee_q), .remainder(ee_r)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg          <= b_next;
            bb_side_reg[0] <= b_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                bb_side_reg[i] <= bb_side_reg[i-1];
            c_reg          <= c_next;
            d_reg          <= c_reg;
            end_reg        <= c_reg.start + c_reg.size - 32'd1;
            dd_side_reg[0] <= d_reg;
            for (int i = 1; i < DIV_STAGES; i++)
                dd_side_reg[i] <= dd_side_reg[i-1];
            ee_side_reg[0] <= ee_in;
            for (int i = 1; i < DIV_STAGES; i++)
                ee_side_reg[i] <= ee_side_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            for (int i = 0; i < DIV_STAGES; i++)
            begin
                bb_vld_reg[i] <= 1'b0;
                dd_vld_reg[i] <= 1'b0;
                ee_vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            b_vld_reg     <= a_vld_reg[DIV_STAGES-1];
            bb_vld_reg[0] <= b_vld_reg;
            c_vld_reg     <= bb_vld_reg[DIV_STAGES-1];
            d_vld_reg     <= c_vld_reg;
            dd_vld_reg[0] <= d_vld_reg;
            ee_vld_reg[0] <= dd_vld_reg[DIV_STAGES-1];
            for (int i = 1; i < DIV_STAGES; i++)
            begin
                bb_vld_reg[i] <= bb_vld_reg[i-1];
                dd_vld_reg[i] <= dd_vld_reg[i-1];
                ee_vld_reg[i] <= ee_vld_reg[i-1];
            end
        end
    end

    // ---- Output stage: pack CHS bytes (all ones past cylinder 1023), zero all fields but status on reject ----
    chs_side_t  f_side;
    logic [7:0] sc_next, sh_next, ss_next, ec_next, eh_next, es_next;
    logic [5:0] sec_s1, sec_e1;

    logic        out_valid_reg;
    logic        status_reg;
    logic [31:0] start_reg, size_reg;
    logic [7:0]  sc_reg, sh_reg, ss_reg, ec_reg, eh_reg, esb_reg;

    assign f_side = ee_side_reg[DIV_STAGES-1];

    always_comb
    begin
        sec_s1  = f_side.sect_s[5:0] + 6'd1;
        sec_e1  = f_side.sect_e[5:0] + 6'd1;
        sc_next = es_q[7:0];
        sh_next = es_r;
        ss_next = {es_q[9:8], sec_s1};
        ec_next = ee_q[7:0];
        eh_next = ee_r;
        es_next = {ee_q[9:8], sec_e1};
        if (es_q > CYL_LIMIT)
        begin
            sc_next = BYTE_ONES;
            sh_next = BYTE_ONES;
            ss_next = BYTE_ONES;
        end
        if (ee_q > CYL_LIMIT)
        begin
            ec_next = BYTE_ONES;
            eh_next = BYTE_ONES;
            es_next = BYTE_ONES;
        end
        if (f_side.base.bad)
        begin
            sc_next = '0;
            sh_next = '0;
            ss_next = '0;
            ec_next = '0;
            eh_next = '0;
            es_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ee_vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= f_side.base.bad;
            start_reg  <= f_side.base.bad ? '0 : f_side.base.start;
            size_reg   <= f_side.base.bad ? '0 : f_side.base.size;
            sc_reg     <= sc_next;
            sh_reg     <= sh_next;
            ss_reg     <= ss_next;
            ec_reg     <= ec_next;
            eh_reg     <= eh_next;
            esb_reg    <= es_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign aligned_start   = start_reg;
    assign aligned_size    = size_reg;
    assign start_cyl_byte  = sc_reg;
    assign start_head_byte = sh_reg;
    assign start_sect_byte = ss_reg;
    assign end_cyl_byte    = ec_reg;
    assign end_head_byte   = eh_reg;
    assign end_sect_byte   = esb_reg;

`ifndef SYNTHESIS
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> aligned_size == '0 && aligned_start == '0)
        else $error("rejected transaction carries nonzero fields");
    a_accept_track: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status |-> aligned_size >= {26'd0, spt_reg})
        else $error("accepted size below one track");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");
`endif

endmodule
`default_nettype wire

[rtl/mpac_div.sv]
// Pipelined 32-bit by 8-bit restoring divider, four quotient bits per stage.
// Depends on mpac_pkg for the stage count.
`default_nettype none
module mpac_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] dividend,
    input  wire logic [7:0]  divisor,
    output logic [31:0]      quotient,
    output logic [7:0]       remainder
);
    import mpac_pkg::*;

    logic [31:0] n_reg [DIV_STAGES];
    logic [31:0] q_reg [DIV_STAGES];
    logic [7:0]  r_reg [DIV_STAGES];
    logic [7:0]  d_reg [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++) begin : g_stage
            logic [31:0] n_in;
            logic [31:0] q_in;
            logic [7:0]  r_in;
            logic [7:0]  d_in;
            logic [31:0] n_next;
            logic [31:0] q_next;
            logic [7:0]  r_next;

            if (s == 0) begin : g_first
                assign n_in = dividend;
                assign q_in = '0;
                assign r_in = '0;
                assign d_in = divisor;
            end
            else begin : g_rest
                assign n_in = n_reg[s-1];
                assign q_in = q_reg[s-1];
                assign r_in = r_reg[s-1];
                assign d_in = d_reg[s-1];
            end

            always_comb
            begin
                logic [8:0] t;
                n_next = n_in;
                q_next = q_in;
                r_next = r_in;
                for (int k = 0; k < DIV_STEPS; k++)
                begin
                    t = {r_next, n_next[31]};
                    n_next = {n_next[30:0], 1'b0};
                    if (t >= {1'b0, d_in})
                    begin
                        t = t - {1'b0, d_in};
                        q_next = {q_next[30:0], 1'b1};
                    end
                    else
                    begin
                        q_next = {q_next[30:0], 1'b0};
                    end
                    r_next = t[7:0];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[s] <= n_next;
                    q_reg[s] <= q_next;
                    r_reg[s] <= r_next;
                    d_reg[s] <= d_in;
                end
            end
        end
    endgenerate

    assign quotient  = q_reg[DIV_STAGES-1];
    assign remainder = r_reg[DIV_STAGES-1];

endmodule
`default_nettype wire
